/* design/crc32_preimage_search_defines.svh */
// ----------------------------------------------------------------------------
// crc32 preimage search assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CRC32_PREIMAGE_SEARCH_DEFINES_SVH
`define CRC32_PREIMAGE_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
`define CPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPS_ASSERT(lbl, prop, msg)
`define CPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/cps_pkg.sv */
// ----------------------------------------------------------------------------
// cps_pkg
// shared constants and types of the crc32 preimage search block
// ----------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

  localparam int CPS_MAX_PATTERN_LEN = 8;
  localparam int CPS_ALPHABET_DEPTH  = 256;

  localparam int CHAR_W = 8;
  localparam int CRC_W  = 32;

  localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INVERT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic init;
    logic step;
  } crc_ctrl_t;

endpackage

`default_nettype wire

/* design/cps_sym_mem.sv */
// ----------------------------------------------------------------------------
// cps_sym_mem
// alphabet table, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module cps_sym_mem
  import cps_pkg::*;
#(
  parameter int DEPTH  = CPS_ALPHABET_DEPTH,
  parameter int ADDR_W = $clog2(CPS_ALPHABET_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [CHAR_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* design/cps_crc_unit.sv */
// ----------------------------------------------------------------------------
// cps_crc_unit
// reflected crc-32 accumulator, one byte per step
// ----------------------------------------------------------------------------
`default_nettype none

module cps_crc_unit
  import cps_pkg::*;
(
  input  wire logic             clk,
  input  wire crc_ctrl_t        ctrl,
  input  wire logic [CRC_W-1:0] seed,
  input  wire logic [CHAR_W-1:0] data_byte,
  output logic      [CRC_W-1:0] crc
);

  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_r ^ {{(CRC_W-CHAR_W){1'b0}}, data_byte};
    for (int k = 0; k < CHAR_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_nxt = c;
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      crc_r <= seed ^ CRC_INVERT;
    end else if (ctrl.step) begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

`default_nettype wire

/* design/crc32_preimage_search.sv */
// ----------------------------------------------------------------------------
// crc32_preimage_search
// brute-force crc-32 preimage search over a loaded alphabet
// ----------------------------------------------------------------------------
// in_* takes command items: load an alphabet entry, restart the odometer, or
// test the current candidate and advance it. Every item gives exactly one
// item on out_*. cfg_* writes start_crc, goal_crc, the candidate length and
// alphabet_size (index 0 to 3); the user must write them only while the
// block is idle, which the block does not enforce; cfg_ready is always high.
// A test item: the first table read is issued at acceptance, then S_CRC makes
// one crc byte step per character through the shared crc unit, S_CHECK does
// the goal compare and odometer carry, and S_EMIT loads the output register.
// Other items, and a test once the search is exhausted, go straight to S_EMIT.
// in_tready is high only between items, so no new item is taken before the
// last one has reached the output register; a new item may be accepted while
// the previous result waits in the output register. When the receiver stalls,
// a finished result waits in its work state until the output register is
// free, and in_tready stays low meanwhile.
// Reset clears the odometer, the exhausted flag and the output valid, and
// sets the registers to their defaults; the alphabet table is undefined
// until written, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "crc32_preimage_search_defines.svh"

module crc32_preimage_search
  import cps_pkg::*;
#(
  parameter int MAX_PATTERN_LEN = CPS_MAX_PATTERN_LEN,
  parameter int ALPHABET_DEPTH  = CPS_ALPHABET_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // cmd [1:0], char_slot [9:2], char_code [17:10]
  input  wire logic [23:0]  in_tdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // hit [0], exhausted [1], candidate_text [65:2], computed_crc [97:66]
  output logic      [103:0] out_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int ADDR_W      = (ALPHABET_DEPTH > 1) ? $clog2(ALPHABET_DEPTH) : 1;
  localparam int IDX_W       = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int TEXT_W      = 64;
  localparam int OUT_PAD     = 104 - CRC_W - TEXT_W - 2;
  localparam int SKIP_DIGITS = 4;

  typedef enum logic [1:0] {
    CMD_LOAD, CMD_RESTART, CMD_TEST, CMD_NOP
  } cmd_t;

  typedef enum logic [1:0] {
    REG_START_CRC, REG_GOAL_CRC, REG_CAND_LEN, REG_ALPHABET_SIZE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE, S_CRC, S_CHECK, S_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [3:0]             len_r, len_nxt;
  logic [CHAR_W-1:0]      digit_r   [MAX_PATTERN_LEN];
  logic [CHAR_W-1:0]      digit_nxt [MAX_PATTERN_LEN];
  logic                   finished_r, finished_nxt;
  logic                   hit_r, hit_nxt;
  logic [TEXT_W-1:0]      text_r, text_nxt;
  logic [CRC_W-1:0]       res_crc_r, res_crc_nxt;
  logic                   oob_r, oob_nxt;

  logic [CRC_W-1:0]       start_crc_r, start_crc_nxt;
  logic [CRC_W-1:0]       goal_crc_r, goal_crc_nxt;
  logic [3:0]             cand_len_r, cand_len_nxt;
  logic [8:0]             alphabet_size_r, alphabet_size_nxt;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic                   out_exh_r, out_exh_nxt;
  logic [TEXT_W-1:0]      out_text_r, out_text_nxt;
  logic [CRC_W-1:0]       out_crc_r, out_crc_nxt;

  logic                   in_acc;
  logic                   cfg_acc;
  cmd_t                   cmd_in;
  logic [CHAR_W-1:0]      slot_in;
  logic [CHAR_W-1:0]      code_in;
  logic [3:0]             len_eff;
  logic [8:0]             size_eff;
  logic [CHAR_W-1:0]      size_m1;

  logic [IDX_W:0]         nxt_pos;
  logic [IDX_W-1:0]       rd_sel;
  logic [CHAR_W-1:0]      rd_digit;
  logic [CHAR_W-1:0]      rd_data;
  logic [CHAR_W-1:0]      sym_byte;
  logic                   wr_en;

  crc_ctrl_t              crc_ctrl;
  logic [CRC_W-1:0]       crc_acc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cmd_in    = cmd_t'(in_tdata[1:0]);
  assign slot_in   = in_tdata[9:2];
  assign code_in   = in_tdata[17:10];

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_crc_r, out_text_r, out_exh_r, out_hit_r};

  // effective length and alphabet size
  always_comb begin
    if (cand_len_r == 4'd0) begin
      len_eff = 4'd1;
    end else if (cand_len_r > 4'(MAX_PATTERN_LEN)) begin
      len_eff = 4'(MAX_PATTERN_LEN);
    end else begin
      len_eff = cand_len_r;
    end
    if (alphabet_size_r == 9'd0) begin
      size_eff = 9'd1;
    end else if (alphabet_size_r > 9'(ALPHABET_DEPTH)) begin
      size_eff = 9'(ALPHABET_DEPTH);
    end else begin
      size_eff = alphabet_size_r;
    end
  end

  assign size_m1 = CHAR_W'(size_eff - 9'd1);

  // table read of the next digit, issued in the cycle before its crc step
  always_comb begin
    nxt_pos = {1'b0, idx_r} + (IDX_W+1)'(1);
    if (state_r == S_CRC && nxt_pos < (IDX_W+1)'(MAX_PATTERN_LEN)) begin
      rd_sel = nxt_pos[IDX_W-1:0];
    end else begin
      rd_sel = '0;
    end
  end

  assign rd_digit = digit_r[rd_sel];
  assign oob_nxt  = ({1'b0, rd_digit} >= 9'(ALPHABET_DEPTH));
  assign sym_byte = oob_r ? '0 : rd_data;
  assign wr_en    = in_acc && (cmd_in == CMD_LOAD) && ({1'b0, slot_in} < 9'(ALPHABET_DEPTH));

  cps_sym_mem #(
    .DEPTH  (ALPHABET_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_sym_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_in[ADDR_W-1:0]),
    .wr_data (code_in),
    .rd_addr (rd_digit[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  cps_crc_unit u_crc_unit (
    .clk       (clk),
    .ctrl      (crc_ctrl),
    .seed      (start_crc_r),
    .data_byte (sym_byte),
    .crc       (crc_acc)
  );

  // configuration writes
  always_comb begin
    start_crc_nxt     = start_crc_r;
    goal_crc_nxt      = goal_crc_r;
    cand_len_nxt      = cand_len_r;
    alphabet_size_nxt = alphabet_size_r;
    if (cfg_acc) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_CRC:     start_crc_nxt     = cfg_data;
        REG_GOAL_CRC:      goal_crc_nxt      = cfg_data;
        REG_CAND_LEN:      cand_len_nxt      = cfg_data[3:0];
        REG_ALPHABET_SIZE: alphabet_size_nxt = cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    logic [CHAR_W-1:0] forced [MAX_PATTERN_LEN];
    logic [CRC_W-1:0]  crc_fin;
    logic [8:0]        inc;
    logic              hit_now;
    logic              carry;

    state_nxt    = state_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    digit_nxt    = digit_r;
    finished_nxt = finished_r;
    hit_nxt      = hit_r;
    text_nxt     = text_r;
    res_crc_nxt  = res_crc_r;
    crc_ctrl     = '0;
    crc_fin      = crc_acc ^ CRC_INVERT;
    hit_now      = (crc_fin == goal_crc_r);
    carry        = 1'b1;
    inc          = '0;
    forced       = digit_r;

    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_hit_nxt    = out_hit_r;
    out_exh_nxt    = out_exh_r;
    out_text_nxt   = out_text_r;
    out_crc_nxt    = out_crc_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          hit_nxt     = 1'b0;
          text_nxt    = '0;
          res_crc_nxt = '0;
          state_nxt   = S_EMIT;
          unique case (cmd_in)
            CMD_RESTART: begin
              for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                digit_nxt[i] = '0;
              end
              finished_nxt = 1'b0;
            end
            CMD_TEST: begin
              if (!finished_r) begin
                crc_ctrl.init = 1'b1;
                idx_nxt       = '0;
                len_nxt       = len_eff;
                state_nxt     = S_CRC;
              end
            end
            default: ;
          endcase
        end
      end
      S_CRC: begin
        crc_ctrl.step                  = 1'b1;
        text_nxt[{idx_r, 3'b000} +: 8] = sym_byte;
        idx_nxt                        = idx_r + IDX_W'(1);
        if (4'(idx_r) == len_r - 4'd1) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_crc_nxt = crc_fin;
        hit_nxt     = hit_now;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
          if (hit_now && len_r >= 4'(SKIP_DIGITS) && i < SKIP_DIGITS) begin
            forced[i] = size_m1;
          end
        end
        digit_nxt = forced;
        // odometer, first digit fastest
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
          inc = {1'b0, forced[i]} + 9'd1;
          if (i < int'(len_r) && carry) begin
            if (inc >= size_eff) begin
              digit_nxt[i] = '0;
            end else begin
              digit_nxt[i] = inc[CHAR_W-1:0];
              carry        = 1'b0;
            end
          end
        end
        finished_nxt = carry;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_hit_nxt    = hit_r;
          out_exh_nxt    = finished_r;
          out_text_nxt   = text_r;
          out_crc_nxt    = res_crc_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      idx_r           <= '0;
      len_r           <= 4'd1;
      for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
        digit_r[i] <= '0;
      end
      finished_r      <= 1'b0;
      out_tvalid_r    <= 1'b0;
      start_crc_r     <= '0;
      goal_crc_r      <= '0;
      cand_len_r      <= 4'd1;
      alphabet_size_r <= 9'd1;
    end else begin
      state_r         <= state_nxt;
      idx_r           <= idx_nxt;
      len_r           <= len_nxt;
      digit_r         <= digit_nxt;
      finished_r      <= finished_nxt;
      out_tvalid_r    <= out_tvalid_nxt;
      start_crc_r     <= start_crc_nxt;
      goal_crc_r      <= goal_crc_nxt;
      cand_len_r      <= cand_len_nxt;
      alphabet_size_r <= alphabet_size_nxt;
    end
    hit_r      <= hit_nxt;
    text_r     <= text_nxt;
    res_crc_r  <= res_crc_nxt;
    oob_r      <= oob_nxt;
    out_hit_r  <= out_hit_nxt;
    out_exh_r  <= out_exh_nxt;
    out_text_r <= out_text_nxt;
    out_crc_r  <= out_crc_nxt;
  end

  `CPS_ASSERT(a_idx_in_len, (state_r == S_CRC) |-> (4'(idx_r) < len_r), "byte index past length")
  `CPS_ASSERT(a_done_sticks, (in_acc && (cmd_in == CMD_TEST) && finished_r) |=> finished_r, "test after exhaustion changed state")
  `CPS_ASSERT(a_restart_clears, (in_acc && (cmd_in == CMD_RESTART)) |=> !finished_r, "restart left exhausted set")
  `CPS_ASSERT_ALWAYS(a_rst_out_idle, !rst_n |=> !out_tvalid_r, "output valid after reset")

endmodule

`default_nettype wire

/* tb/sv/crc32_preimage_search_tb_pkg.sv */
// ----------------------------------------------------------------------------
// crc32_preimage_search_tb_pkg
// command codes, register indexes and item layouts shared by the testbench
// ----------------------------------------------------------------------------
package crc32_preimage_search_tb_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_TEST    = 2'd2,
    CMD_UNUSED  = 2'd3
  } search_cmd_t;

  typedef enum logic [1:0] {
    REG_START_CRC     = 2'd0,
    REG_GOAL_CRC      = 2'd1,
    REG_CAND_LEN      = 2'd2,
    REG_ALPHABET_SIZE = 2'd3
  } search_reg_t;

  // in_tdata[17:0], lowest field last
  typedef struct packed {
    logic [7:0]  char_code;
    logic [7:0]  char_slot;
    search_cmd_t cmd;
  } search_item_t;

  // out_tdata[97:0], lowest field last
  typedef struct packed {
    logic [31:0] computed_crc;
    logic [63:0] candidate_text;
    logic        exhausted;
    logic        hit;
  } search_result_t;

endpackage

/* tb/sv/crc32_preimage_search_checker.sv */
// ----------------------------------------------------------------------------
// crc32_preimage_search_checker
// watches the command, result and register channels of the search block,
// keeps its own copy of the alphabet, odometer and registers, predicts the
// result of every accepted item and compares results in order, field by field
// ----------------------------------------------------------------------------
module crc32_preimage_search_checker
  import cps_pkg::*;
  import crc32_preimage_search_tb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic [23:0]  in_tdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] out_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         end_check,
  output int           fail_count
);

  logic [31:0] start_crc;
  logic [31:0] goal_crc;
  logic [3:0]  cand_len;
  logic [8:0]  alphabet_size;
  logic [7:0]  symbols [CPS_ALPHABET_DEPTH];
  logic [7:0]  digits  [CPS_MAX_PATTERN_LEN];
  logic        exhausted;
  logic        end_seen;

  search_result_t pending_results [$];

  function automatic logic [31:0] crc_byte_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic search_result_t predict_search_step(search_item_t item);
    search_result_t r;
    int             len;
    int             size;
    int             next;
    logic [31:0]    crc;
    logic           carry;
    r = '0;
    case (item.cmd)
      CMD_LOAD: begin
        symbols[item.char_slot] = item.char_code;
      end
      CMD_RESTART: begin
        foreach (digits[i]) digits[i] = '0;
        exhausted = 1'b0;
      end
      CMD_TEST: begin
        if (!exhausted) begin
          len = (cand_len == 0) ? 1 :
                (cand_len > CPS_MAX_PATTERN_LEN) ? CPS_MAX_PATTERN_LEN : cand_len;
          size = (alphabet_size == 0) ? 1 :
                 (alphabet_size > CPS_ALPHABET_DEPTH) ? CPS_ALPHABET_DEPTH : alphabet_size;
          crc = start_crc ^ CRC_INVERT;
          for (int i = 0; i < len; i++) begin
            r.candidate_text[8*i +: 8] = symbols[digits[i]];
            crc = crc_byte_step(crc, symbols[digits[i]]);
          end
          crc = crc ^ CRC_INVERT;
          r.computed_crc = crc;
          if (crc == goal_crc) begin
            r.hit = 1'b1;
            // skip the rest of this four-character block
            if (len >= 4) begin
              for (int i = 0; i < 4; i++) digits[i] = 8'(size - 1);
            end
          end
          carry = 1'b1;
          for (int i = 0; i < len && carry; i++) begin
            next = digits[i] + 1;
            if (next >= size) begin
              digits[i] = '0;
            end else begin
              digits[i] = 8'(next);
              carry = 1'b0;
            end
          end
          if (carry) exhausted = 1'b1;
        end
      end
      default: ;
    endcase
    r.exhausted = exhausted;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    search_result_t got;
    search_result_t want;
    if (!rst_n) begin
      start_crc     = '0;
      goal_crc      = '0;
      cand_len      = 4'd1;
      alphabet_size = 9'd1;
      foreach (digits[i]) digits[i] = '0;
      exhausted  = 1'b0;
      end_seen   = 1'b0;
      fail_count = 0;
      pending_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[97:0];
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item: %h", got);
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit || got.exhausted !== want.exhausted ||
              got.candidate_text !== want.candidate_text ||
              got.computed_crc !== want.computed_crc) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch (expected/actual): hit %b/%b exhausted %b/%b",
                       want.hit, got.hit, want.exhausted, got.exhausted);
              $display("  text %h/%h crc %h/%h", want.candidate_text,
                       got.candidate_text, want.computed_crc, got.computed_crc);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_CRC:     start_crc     = cfg_data;
          REG_GOAL_CRC:      goal_crc      = cfg_data;
          REG_CAND_LEN:      cand_len      = cfg_data[3:0];
          REG_ALPHABET_SIZE: alphabet_size = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(predict_search_step(search_item_t'(in_tdata[17:0])));
      end
      if (end_check && !end_seen) begin
        end_seen = 1'b1;
        if (pending_results.size() != 0) begin
          fail_count += pending_results.size();
          $display("%0d expected result items never arrived", pending_results.size());
        end
      end
    end
  end

endmodule

/* tb/sv/crc32_preimage_search_tb.sv */
// ----------------------------------------------------------------------------
// crc32_preimage_search_tb
// drives command items and register writes into the search block under
// bursty input and stalling output; a checker beside the block predicts and
// compares every result, and goals are often taken from crcs seen earlier
// so that hits, forced carries and exhaustion all occur
// ----------------------------------------------------------------------------
module crc32_preimage_search_tb;
  import cps_pkg::*;
  import crc32_preimage_search_tb_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int ITEM_TARGET    = 1200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 250;

  logic         clk;
  logic         rst_n;
  logic [23:0]  in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         end_check;
  int           fail_count;

  int items_sent     = 0;
  int results_seen   = 0;
  int tests_seen     = 0;
  int hits_seen      = 0;
  int exhausted_seen = 0;
  int hold_cycles    = 0;
  int ready_mode     = 0;
  int ready_tick     = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;
  bit sender_idles   = 1'b0;

  logic [31:0] cur_start;
  logic [31:0] cur_goal;
  logic [3:0]  cur_len;
  logic [8:0]  cur_size;
  logic [31:0] seen_crcs [$];

  search_result_t out_item;
  assign out_item = out_tdata[97:0];

  crc32_preimage_search u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  crc32_preimage_search_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .end_check  (end_check),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: counts results, keeps their crcs as future goals, stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      hits_seen += out_item.hit;
      exhausted_seen += out_item.exhausted;
      if (out_item.candidate_text != '0 || out_item.computed_crc != '0) begin
        tests_seen++;
        seen_crcs.push_back(out_item.computed_crc);
      end
    end
    ready_tick++;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(3) != 0);
        2: out_tready <= ($urandom_range(3) == 0);
        default: out_tready <= ((ready_tick % 7) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_item(search_cmd_t cmd, logic [7:0] slot, logic [7:0] code);
    search_item_t item;
    int           gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = sender_idles ? $urandom_range(12, 1) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.cmd       = cmd;
    item.char_slot = slot;
    item.char_code = code;
    in_tdata  <= {6'd0, item};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic write_reg(search_reg_t idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic [31:0] start, logic [31:0] goal, logic [3:0] len,
                           logic [8:0] size);
    logic [31:0] noise;
    noise = $urandom();
    wait_for_results();
    write_reg(REG_START_CRC, start);
    write_reg(REG_GOAL_CRC, goal);
    write_reg(REG_CAND_LEN, {noise[31:4], len});
    write_reg(REG_ALPHABET_SIZE, {noise[31:9], size});
    cfg_valid <= 1'b0;
    cur_start = start;
    cur_goal  = goal;
    cur_len   = len;
    cur_size  = size;
  endtask

  task automatic send_tests(int n);
    repeat (n) send_item(CMD_TEST, 8'($urandom()), 8'($urandom()));
  endtask

  initial begin : stimulus
    logic [31:0] goal_pick;
    logic [31:0] start_pick;
    logic [3:0]  len_pick;
    logic [8:0]  size_pick;
    int          n;
    int          pick;
    bit          replay;
    bit          first_phase;
    rst_n      = 1'b0;
    in_tdata   = '0;
    in_tvalid  = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    end_check  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // every table entry gets written before any candidate is read
    sender_idles = 1'b1;
    ready_mode   = 1;
    for (int s = 0; s < CPS_ALPHABET_DEPTH; s++) begin
      send_item(CMD_LOAD, 8'(s), 8'($urandom()));
    end

    // reset settings: one character, one symbol
    send_item(CMD_LOAD, 8'h00, 8'h00);
    send_item(CMD_LOAD, 8'hFF, 8'hFF);
    send_item(CMD_TEST, 8'h00, 8'h00);
    send_item(CMD_TEST, 8'hFF, 8'hFF);
    send_item(CMD_UNUSED, 8'hFF, 8'hFF);
    send_item(CMD_RESTART, 8'h00, 8'h00);
    send_item(CMD_TEST, 8'h00, 8'h00);

    // zero length and size act as one
    configure(32'hFFFF_FFFF, 32'h0, 4'd0, 9'd0);
    send_item(CMD_RESTART, 8'hFF, 8'h00);
    send_tests(1);

    // oversized length and size saturate
    configure(32'h0, 32'hFFFF_FFFF, 4'd15, 9'd511);
    send_item(CMD_RESTART, 8'h00, 8'hFF);
    send_tests(2);

    // long pattern hit: harvest a crc, then search for it
    configure($urandom(), 32'h0, 4'd8, 9'd4);
    seen_crcs.delete();
    send_item(CMD_RESTART, 8'h00, 8'h00);
    send_tests(3);
    wait_for_results();
    goal_pick = (seen_crcs.size() > 1) ? seen_crcs[1] : 32'h0;
    configure(cur_start, goal_pick, 4'd8, 9'd4);
    send_item(CMD_RESTART, 8'h00, 8'h00);
    send_tests(4);

    // alphabet shrinks under a running search
    configure($urandom(), $urandom(), 4'd2, 9'd8);
    send_item(CMD_RESTART, 8'h00, 8'h00);
    send_tests(6);
    configure(cur_start, cur_goal, 4'd2, 9'd3);
    send_tests(3);

    first_phase = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      replay = ($urandom_range(9) < 5) && (seen_crcs.size() > 0);
      if (replay) begin
        goal_pick = seen_crcs[$urandom_range(seen_crcs.size() - 1)];
        configure(cur_start, goal_pick, cur_len, cur_size);
      end else begin
        pick = $urandom_range(9);
        start_pick = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
        pick = $urandom_range(19);
        if (pick < 8)       len_pick = 4'($urandom_range(2, 1));
        else if (pick < 14) len_pick = 4'($urandom_range(4, 3));
        else if (pick == 14) len_pick = 4'd0;
        else if (pick == 15) len_pick = 4'd8;
        else if (pick == 16) len_pick = 4'($urandom_range(15, 9));
        else                len_pick = 4'($urandom_range(7, 5));
        pick = $urandom_range(19);
        if (pick < 10)       size_pick = 9'($urandom_range(6, 1));
        else if (pick < 13)  size_pick = 9'($urandom_range(40, 7));
        else if (pick == 13) size_pick = 9'd0;
        else if (pick == 14) size_pick = 9'd256;
        else if (pick == 15) size_pick = 9'($urandom_range(511, 257));
        else                 size_pick = 9'($urandom_range(255, 41));
        goal_pick = ($urandom_range(7) == 0) ? 32'h0 : $urandom();
        configure(start_pick, goal_pick, len_pick, size_pick);
      end
      seen_crcs.delete();
      ready_mode   = $urandom_range(3);
      sender_idles = ($urandom_range(3) != 0);
      if (first_phase || $urandom_range(9) == 0) hold_cycles = LONG_HOLD;
      first_phase = 1'b0;
      // without a restart the search goes on under the new settings
      if (replay || $urandom_range(4) != 0) send_item(CMD_RESTART, 8'($urandom()), 8'($urandom()));
      n = $urandom_range(60, 10);
      repeat (n) begin
        pick = $urandom_range(99);
        if (pick < 78)      send_item(CMD_TEST, 8'($urandom()), 8'($urandom()));
        else if (pick < 88) send_item(CMD_LOAD, 8'($urandom()), 8'($urandom()));
        else if (pick < 94) send_item(CMD_RESTART, 8'($urandom()), 8'($urandom()));
        else                send_item(CMD_UNUSED, 8'($urandom()), 8'($urandom()));
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    $display("run covered %0d items: %0d candidates tested, %0d hits,", items_sent,
             tests_seen, hits_seen);
    $display("%0d results reporting an exhausted search", exhausted_seen);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
